// ===== hdl/mmlp_pkg.sv =====
// shared types, character codes and helper functions for the memory-map line parser
package mmlp_pkg;

  localparam int MMLP_POSITION_BITS = 32;

  localparam logic STATUS_RECORD = 1'b0;
  localparam logic STATUS_ERROR  = 1'b1;

  localparam logic [7:0] CH_DASH  = 8'h2D;
  localparam logic [7:0] CH_COLON = 8'h3A;
  localparam logic [7:0] CH_SLASH = 8'h2F;
  localparam logic [7:0] CH_SPACE = 8'h20;
  localparam logic [7:0] CH_TAB   = 8'h09;
  localparam logic [7:0] CH_NL    = 8'h0A;
  localparam logic [7:0] CH_VT    = 8'h0B;
  localparam logic [7:0] CH_FF    = 8'h0C;
  localparam logic [7:0] CH_CR    = 8'h0D;
  localparam logic [7:0] CH_R     = 8'h72;
  localparam logic [7:0] CH_W     = 8'h77;
  localparam logic [7:0] CH_X     = 8'h78;
  localparam logic [7:0] CH_P     = 8'h70;
  localparam logic [7:0] CH_S     = 8'h73;
  localparam logic [7:0] CH_0     = 8'h30;
  localparam logic [7:0] CH_9     = 8'h39;

  typedef struct packed {
    logic        status;
    logic [63:0] start_addr;
    logic [63:0] region_length;
    logic [2:0]  protection;
    logic [31:0] device;
    logic [31:0] inode;
    logic [63:0] file_offset;
    logic        has_name;
    logic [31:0] name_pos;
    logic [31:0] name_len;
  } mmlp_result_t;

  // {is hex digit, digit value}
  function automatic logic [4:0] hex_digit(input logic [7:0] c);
    logic [4:0] r;
    r = 5'b0;
    if (c >= 8'h30 && c <= 8'h39) begin
      r = {1'b1, 4'(c - 8'h30)};
    end else if (c >= 8'h61 && c <= 8'h66) begin
      r = {1'b1, 4'(c - 8'h57)};
    end else if (c >= 8'h41 && c <= 8'h46) begin
      r = {1'b1, 4'(c - 8'h37)};
    end
    return r;
  endfunction

  function automatic logic is_space(input logic [7:0] c);
    return (c == CH_SPACE) || (c == CH_TAB) || (c == CH_NL) ||
           (c == CH_VT) || (c == CH_FF) || (c == CH_CR);
  endfunction

endpackage

// ===== hdl/mmlp_core.sv =====
// input word register, per-byte parse step and line state of the parser
module mmlp_core #(
  parameter int POSITION_BITS = mmlp_pkg::MMLP_POSITION_BITS
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  text_valid,
  output logic                  text_ready,
  input  logic [7:0]            text_byte,
  input  logic                  end_of_text,
  input  logic                  out_free,
  output logic                  emit,
  output mmlp_pkg::mmlp_result_t result
);
  import mmlp_pkg::*;

  localparam logic [3:0] PH_START = 4'd0;
  localparam logic [3:0] PH_END   = 4'd1;
  localparam logic [3:0] PH_PR    = 4'd2;
  localparam logic [3:0] PH_PW    = 4'd3;
  localparam logic [3:0] PH_PX    = 4'd4;
  localparam logic [3:0] PH_PP    = 4'd5;
  localparam logic [3:0] PH_SP    = 4'd6;
  localparam logic [3:0] PH_OFF   = 4'd7;
  localparam logic [3:0] PH_MAJ   = 4'd8;
  localparam logic [3:0] PH_MIN   = 4'd9;
  localparam logic [3:0] PH_INO   = 4'd10;
  localparam logic [3:0] PH_TAIL  = 4'd11;
  localparam logic [3:0] PH_ERR   = 4'd12;

  localparam int PB = POSITION_BITS;

  // input word register
  logic       s1_valid;
  logic [7:0] s1_byte;
  logic       s1_eot;
  logic       fire;

  // line state
  logic [3:0]    phase, phase_next;
  logic [63:0]   start_acc, start_acc_next;
  logic [63:0]   end_acc, end_acc_next;
  logic [63:0]   offset_acc, offset_acc_next;
  logic [31:0]   major_acc, major_acc_next;
  logic [31:0]   minor_acc, minor_acc_next;
  logic [31:0]   inode_acc, inode_acc_next;
  logic [2:0]    perm_bits, perm_bits_next;
  logic          digit_count, digit_count_next;
  logic [PB-1:0] byte_position;
  logic [PB-1:0] token_start, token_start_next;
  logic [PB-1:0] token_length, token_length_next;
  logic          token_slash, token_slash_next;

  logic [4:0]  hx;
  logic        is_hex;
  logic [3:0]  hv;
  logic        is_dec;
  logic        rec, err;
  logic        named;
  logic [31:0] name_pos_w, name_len_w;

  assign fire       = s1_valid && out_free;
  assign text_ready = !s1_valid || fire;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (text_valid && text_ready) begin
      s1_valid <= 1'b1;
    end else if (fire) begin
      s1_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (text_valid && text_ready) begin
      s1_byte <= text_byte;
      s1_eot  <= end_of_text;
    end
  end

  assign hx     = hex_digit(s1_byte);
  assign is_hex = hx[4];
  assign hv     = hx[3:0];
  assign is_dec = (s1_byte >= CH_0) && (s1_byte <= CH_9);

  always_comb begin
    phase_next         = phase;
    start_acc_next     = start_acc;
    end_acc_next       = end_acc;
    offset_acc_next    = offset_acc;
    major_acc_next     = major_acc;
    minor_acc_next     = minor_acc;
    inode_acc_next     = inode_acc;
    perm_bits_next     = perm_bits;
    digit_count_next   = digit_count;
    token_start_next   = token_start;
    token_length_next  = token_length;
    token_slash_next   = token_slash;
    rec                = 1'b0;
    err                = 1'b0;

    case (phase)
      PH_START: begin
        if (is_hex) begin
          start_acc_next   = {start_acc[59:0], hv};
          digit_count_next = 1'b1;
        end else if (digit_count && s1_byte == CH_DASH) begin
          digit_count_next = 1'b0;
          phase_next       = PH_END;
        end else begin
          err = 1'b1;
        end
      end
      PH_END: begin
        if (is_hex) begin
          end_acc_next     = {end_acc[59:0], hv};
          digit_count_next = 1'b1;
        end else if (digit_count && s1_byte == CH_SPACE) begin
          digit_count_next = 1'b0;
          phase_next       = PH_PR;
        end else begin
          err = 1'b1;
        end
      end
      PH_PR: begin
        if (s1_byte == CH_R) perm_bits_next = perm_bits | 3'b001;
        if (s1_byte == CH_R || s1_byte == CH_DASH) phase_next = PH_PW;
        else err = 1'b1;
      end
      PH_PW: begin
        if (s1_byte == CH_W) perm_bits_next = perm_bits | 3'b010;
        if (s1_byte == CH_W || s1_byte == CH_DASH) phase_next = PH_PX;
        else err = 1'b1;
      end
      PH_PX: begin
        if (s1_byte == CH_X) perm_bits_next = perm_bits | 3'b100;
        if (s1_byte == CH_X || s1_byte == CH_DASH) phase_next = PH_PP;
        else err = 1'b1;
      end
      PH_PP: begin
        if (s1_byte == CH_P || s1_byte == CH_S || s1_byte == CH_DASH) phase_next = PH_SP;
        else err = 1'b1;
      end
      PH_SP: begin
        if (s1_byte == CH_SPACE) begin
          phase_next       = PH_OFF;
          digit_count_next = 1'b0;
        end else begin
          err = 1'b1;
        end
      end
      PH_OFF: begin
        if (is_hex) begin
          offset_acc_next  = {offset_acc[59:0], hv};
          digit_count_next = 1'b1;
        end else if (digit_count && s1_byte == CH_SPACE) begin
          digit_count_next = 1'b0;
          phase_next       = PH_MAJ;
        end else begin
          err = 1'b1;
        end
      end
      PH_MAJ: begin
        if (is_hex) begin
          major_acc_next   = {major_acc[27:0], hv};
          digit_count_next = 1'b1;
        end else if (digit_count && s1_byte == CH_COLON) begin
          digit_count_next = 1'b0;
          phase_next       = PH_MIN;
        end else begin
          err = 1'b1;
        end
      end
      PH_MIN: begin
        if (is_hex) begin
          minor_acc_next   = {minor_acc[27:0], hv};
          digit_count_next = 1'b1;
        end else if (digit_count && s1_byte == CH_SPACE) begin
          digit_count_next  = 1'b0;
          phase_next        = PH_INO;
          token_length_next = '0;
          token_start_next  = '0;
          token_slash_next  = 1'b0;
        end else begin
          err = 1'b1;
        end
      end
      PH_INO, PH_TAIL: begin
        if (phase == PH_INO && is_dec) begin
          inode_acc_next   = {inode_acc[28:0], 3'b000} + {inode_acc[30:0], 1'b0} +
                             {28'b0, hv};
          digit_count_next = 1'b1;
        end else if (phase == PH_INO && !digit_count) begin
          err = 1'b1;
        end else begin
          phase_next = PH_TAIL;
        end
        if (!err) begin
          if ((phase_next == PH_TAIL) && s1_byte == CH_NL) begin
            rec = 1'b1;
          end else if ((phase_next == PH_TAIL) && is_space(s1_byte)) begin
            token_length_next = '0;
          end else begin
            // extend the last token
            if (token_length == '0) begin
              token_start_next = byte_position;
              token_slash_next = (s1_byte == CH_SLASH);
            end
            if (token_length != '1) token_length_next = token_length + PB'(1);
          end
        end
      end
      PH_ERR: begin
      end
      default: begin
        err = 1'b1;
      end
    endcase

    // end of text closes the line
    if (!rec && !err && s1_eot && phase_next != PH_ERR) begin
      if (phase_next == PH_TAIL || (phase_next == PH_INO && digit_count_next)) rec = 1'b1;
      else err = 1'b1;
    end
  end

  assign named = token_slash_next && (token_length_next >= PB'(2));

  generate
    if (PB >= 32) begin : g_pos_trunc
      assign name_pos_w = token_start_next[31:0];
      assign name_len_w = token_length_next[31:0];
    end else begin : g_pos_ext
      assign name_pos_w = {{(32-PB){1'b0}}, token_start_next};
      assign name_len_w = {{(32-PB){1'b0}}, token_length_next};
    end
  endgenerate

  always_comb begin
    result = '0;
    if (rec) begin
      result.status        = STATUS_RECORD;
      result.start_addr    = start_acc_next;
      result.region_length = end_acc_next - start_acc_next;
      result.protection    = perm_bits_next;
      result.device        = {major_acc_next[23:0], 8'h00} + minor_acc_next;
      result.inode         = inode_acc_next;
      result.file_offset   = named ? offset_acc_next : 64'd0;
      result.has_name      = named;
      result.name_pos      = named ? name_pos_w : 32'd0;
      result.name_len      = named ? name_len_w : 32'd0;
    end else begin
      result.status = STATUS_ERROR;
    end
  end

  assign emit = fire && (rec || err);

  always_ff @(posedge clk) begin
    if (rst) begin
      phase         <= PH_START;
      start_acc     <= '0;
      end_acc       <= '0;
      offset_acc    <= '0;
      major_acc     <= '0;
      minor_acc     <= '0;
      inode_acc     <= '0;
      perm_bits     <= '0;
      digit_count   <= 1'b0;
      byte_position <= '0;
      token_start   <= '0;
      token_length  <= '0;
      token_slash   <= 1'b0;
    end else if (fire) begin
      if (rec || err || s1_eot) begin
        start_acc    <= '0;
        end_acc      <= '0;
        offset_acc   <= '0;
        major_acc    <= '0;
        minor_acc    <= '0;
        inode_acc    <= '0;
        perm_bits    <= '0;
        digit_count  <= 1'b0;
        token_start  <= '0;
        token_length <= '0;
        token_slash  <= 1'b0;
        phase        <= (err && !s1_eot) ? PH_ERR : PH_START;
      end else begin
        phase        <= phase_next;
        start_acc    <= start_acc_next;
        end_acc      <= end_acc_next;
        offset_acc   <= offset_acc_next;
        major_acc    <= major_acc_next;
        minor_acc    <= minor_acc_next;
        inode_acc    <= inode_acc_next;
        perm_bits    <= perm_bits_next;
        digit_count  <= digit_count_next;
        token_start  <= token_start_next;
        token_length <= token_length_next;
        token_slash  <= token_slash_next;
      end
      byte_position <= s1_eot ? '0 : byte_position + PB'(1);
    end
  end

  a_emit_needs_word: assert property (@(posedge clk) disable iff (rst)
    emit |-> s1_valid && out_free)
    else $error("result produced without a word in the input register");

  a_eot_restarts: assert property (@(posedge clk) disable iff (rst)
    fire && s1_eot |=> byte_position == '0 && phase == PH_START)
    else $error("end of text did not restart the parser");

  a_err_zero_fields: assert property (@(posedge clk) disable iff (rst)
    emit && result.status |-> result.start_addr == 64'd0 && !result.has_name &&
                              result.name_len == 32'd0)
    else $error("error result carries nonzero fields");

  a_err_holds: assert property (@(posedge clk) disable iff (rst)
    fire && err && !s1_eot |=> phase == PH_ERR)
    else $error("syntax error did not enter the error phase");

endmodule

// ===== hdl/mmlp_out.sv =====
// result register between the parse step and the result channel
module mmlp_out (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   load,
  input  mmlp_pkg::mmlp_result_t load_data,
  output logic                   free,
  output logic                   result_valid,
  input  logic                   result_ready,
  output mmlp_pkg::mmlp_result_t data
);
  import mmlp_pkg::*;

  assign free = !result_valid || result_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
    end else if (load && free) begin
      result_valid <= 1'b1;
    end else if (result_ready) begin
      result_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load && free) begin
      data <= load_data;
    end
  end

endmodule

// ===== hdl/memory_map_line_parser.sv =====
// top level of the memory-map line parser
//
// text channel: one byte of map text per word (text_byte) with end_of_text
// marking the last byte; text_valid / text_ready handshake.
// result channel: one record per line end (newline or end of text), or one
// error word on a syntax error; result_valid / result_ready handshake.
// after an error, bytes are dropped until the end-of-text byte.
// path: a byte is registered in the input word register on acceptance and is
// parsed from there; its result is loaded into the result register once that
// register is free, and result_valid rises with that load.
// throughput: one byte per cycle while result_ready holds no result back; the
// parse step with its shift-add accumulators is combinational.
// reset: parser expects a start address, byte position is zero, no word is
// held in either register.
// stall: while result_ready is low and a result is held, the parse step
// waits; at most one more byte is taken into the input register, then
// text_ready drops until the result is taken.
module memory_map_line_parser #(
  parameter int POSITION_BITS = mmlp_pkg::MMLP_POSITION_BITS
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        text_valid,
  output logic        text_ready,
  input  logic [7:0]  text_byte,
  input  logic        end_of_text,
  output logic        result_valid,
  input  logic        result_ready,
  output logic        status,
  output logic [63:0] start_addr,
  output logic [63:0] region_length,
  output logic [2:0]  protection,
  output logic [31:0] device,
  output logic [31:0] inode,
  output logic [63:0] file_offset,
  output logic        has_name,
  output logic [31:0] name_pos,
  output logic [31:0] name_len
);
  import mmlp_pkg::*;

  logic         out_free;
  logic         emit;
  mmlp_result_t core_result;
  mmlp_result_t held;

  mmlp_core #(
    .POSITION_BITS(POSITION_BITS)
  ) u_core (
    .clk         (clk),
    .rst         (rst),
    .text_valid  (text_valid),
    .text_ready  (text_ready),
    .text_byte   (text_byte),
    .end_of_text (end_of_text),
    .out_free    (out_free),
    .emit        (emit),
    .result      (core_result)
  );

  mmlp_out u_out (
    .clk          (clk),
    .rst          (rst),
    .load         (emit),
    .load_data    (core_result),
    .free         (out_free),
    .result_valid (result_valid),
    .result_ready (result_ready),
    .data         (held)
  );

  assign status        = held.status;
  assign start_addr    = held.start_addr;
  assign region_length = held.region_length;
  assign protection    = held.protection;
  assign device        = held.device;
  assign inode         = held.inode;
  assign file_offset   = held.file_offset;
  assign has_name      = held.has_name;
  assign name_pos      = held.name_pos;
  assign name_len      = held.name_len;

endmodule

// ===== verif/tb_memory_map_line_parser.sv =====
// testbench for memory_map_line_parser: directed and random map text checked by a byte-level parser model
module tb_memory_map_line_parser;
  timeunit 1ns;
  timeprecision 1ps;
  import mmlp_pkg::*;

  localparam int IDLE_LIMIT = 2000;
  localparam int HOLD_CYCLES = 120;
  localparam int RANDOM_BYTES = 80;
  localparam int RANDOM_RESULTS = 2;
  localparam int MAX_REPORTS = 10;
  localparam int RDY_ALWAYS = 0;
  localparam int RDY_HALF = 1;
  localparam int RDY_SPARSE = 2;
  localparam string HEX_LOWER = "0123456789abcdef";
  localparam string HEX_UPPER = "0123456789ABCDEF";
  localparam string NAME_CHARS = "abcdefghijklmnopqrstuvwxyz0123456789._-/+@";

  typedef enum logic [3:0] {
    LN_START, LN_END_ADDR, LN_PERM_R, LN_PERM_W, LN_PERM_X, LN_PERM_SHARE,
    LN_PERM_SPACE, LN_OFFSET, LN_MAJOR, LN_MINOR, LN_INODE, LN_TAIL, LN_SKIP
  } line_phase_t;

  typedef enum logic [1:0] {HEX_DIGIT, HEX_SEP, HEX_BAD} hex_scan_t;

  logic        clk;
  logic        rst = 1'b1;
  logic        text_valid = 1'b0;
  logic        text_ready;
  logic [7:0]  text_byte = 8'h00;
  logic        end_of_text = 1'b0;
  logic        result_valid;
  logic        result_ready = 1'b0;
  logic        status;
  logic [63:0] start_addr;
  logic [63:0] region_length;
  logic [2:0]  protection;
  logic [31:0] device;
  logic [31:0] inode;
  logic [63:0] file_offset;
  logic        has_name;
  logic [31:0] name_pos;
  logic [31:0] name_len;

  memory_map_line_parser u_dut (
    .clk, .rst, .text_valid, .text_ready, .text_byte, .end_of_text,
    .result_valid, .result_ready, .status, .start_addr, .region_length,
    .protection, .device, .inode, .file_offset, .has_name, .name_pos, .name_len
  );

  always begin
    clk = 1'b0;
    #2;
    clk = 1'b1;
    #2;
  end

  // parser model state
  line_phase_t ln_phase = LN_START;
  logic [63:0] acc_start, acc_end, acc_offset;
  logic [31:0] acc_major, acc_minor, acc_inode;
  logic [2:0]  acc_perm;
  logic        digit_seen;
  logic [31:0] text_pos = '0;
  logic [31:0] tok_start, tok_len;
  logic        tok_slash;

  mmlp_result_t expected_records[$];
  logic [7:0]   text_q[$];
  int mismatches = 0;
  int records_predicted = 0;
  int bytes_sent = 0;
  int burst_left = 0;
  int hold_requests = 0;
  int holds_served = 0;
  int hold_left = 0;
  int ready_mode = RDY_ALWAYS;
  int mode_left = 0;
  int idle_cycles = 0;

  function automatic void clear_line_state();
    acc_start = '0;
    acc_end = '0;
    acc_offset = '0;
    acc_major = '0;
    acc_minor = '0;
    acc_inode = '0;
    acc_perm = '0;
    digit_seen = 1'b0;
    tok_start = '0;
    tok_len = '0;
    tok_slash = 1'b0;
  endfunction

  function automatic logic is_blank(input logic [7:0] c);
    case (c)
      CH_SPACE, CH_TAB, CH_NL, CH_VT, CH_FF, CH_CR: return 1'b1;
      default: return 1'b0;
    endcase
  endfunction

  function automatic logic [4:0] nibble_of(input logic [7:0] c);
    for (int i = 0; i < 16; i++) begin
      if (c == HEX_LOWER[i] || c == HEX_UPPER[i]) return {1'b1, 4'(i)};
    end
    return 5'd0;
  endfunction

  function automatic hex_scan_t hex_scan(inout logic [63:0] acc, input logic [7:0] c,
                                         input logic [7:0] sep);
    logic [4:0] n;
    n = nibble_of(c);
    if (n[4]) begin
      acc = {acc[59:0], n[3:0]};
      digit_seen = 1'b1;
      return HEX_DIGIT;
    end
    if (digit_seen && c == sep) begin
      digit_seen = 1'b0;
      return HEX_SEP;
    end
    return HEX_BAD;
  endfunction

  function automatic void note_token(input logic [7:0] c, input logic [31:0] pos);
    if (tok_len == 0) begin
      tok_start = pos;
      tok_slash = (c == CH_SLASH);
    end
    if (tok_len != '1) tok_len++;
  endfunction

  // returns 1 at a line end
  function automatic logic tail_char(input logic [7:0] c, input logic [31:0] pos);
    if (c == CH_NL) return 1'b1;
    if (is_blank(c)) tok_len = '0;
    else note_token(c, pos);
    return 1'b0;
  endfunction

  function automatic void parse_map_byte(input logic [7:0] c, input logic eot);
    mmlp_result_t rec;
    logic emit_rec, emit_err, named;
    logic [31:0] pos;
    logic [63:0] wide;
    hex_scan_t hs;
    pos = text_pos;
    emit_rec = 1'b0;
    emit_err = 1'b0;
    case (ln_phase)
      LN_START: begin
        hs = hex_scan(acc_start, c, CH_DASH);
        if (hs == HEX_SEP) ln_phase = LN_END_ADDR;
        else if (hs == HEX_BAD) emit_err = 1'b1;
      end
      LN_END_ADDR: begin
        hs = hex_scan(acc_end, c, CH_SPACE);
        if (hs == HEX_SEP) ln_phase = LN_PERM_R;
        else if (hs == HEX_BAD) emit_err = 1'b1;
      end
      LN_PERM_R: begin
        if (c == CH_R) acc_perm[0] = 1'b1;
        if (c == CH_R || c == CH_DASH) ln_phase = LN_PERM_W;
        else emit_err = 1'b1;
      end
      LN_PERM_W: begin
        if (c == CH_W) acc_perm[1] = 1'b1;
        if (c == CH_W || c == CH_DASH) ln_phase = LN_PERM_X;
        else emit_err = 1'b1;
      end
      LN_PERM_X: begin
        if (c == CH_X) acc_perm[2] = 1'b1;
        if (c == CH_X || c == CH_DASH) ln_phase = LN_PERM_SHARE;
        else emit_err = 1'b1;
      end
      LN_PERM_SHARE: begin
        if (c == CH_P || c == CH_S || c == CH_DASH) ln_phase = LN_PERM_SPACE;
        else emit_err = 1'b1;
      end
      LN_PERM_SPACE: begin
        if (c == CH_SPACE) begin
          ln_phase = LN_OFFSET;
          digit_seen = 1'b0;
        end else begin
          emit_err = 1'b1;
        end
      end
      LN_OFFSET: begin
        hs = hex_scan(acc_offset, c, CH_SPACE);
        if (hs == HEX_SEP) ln_phase = LN_MAJOR;
        else if (hs == HEX_BAD) emit_err = 1'b1;
      end
      LN_MAJOR: begin
        wide = {32'd0, acc_major};
        hs = hex_scan(wide, c, CH_COLON);
        acc_major = wide[31:0];
        if (hs == HEX_SEP) ln_phase = LN_MINOR;
        else if (hs == HEX_BAD) emit_err = 1'b1;
      end
      LN_MINOR: begin
        wide = {32'd0, acc_minor};
        hs = hex_scan(wide, c, CH_SPACE);
        acc_minor = wide[31:0];
        if (hs == HEX_SEP) begin
          ln_phase = LN_INODE;
          tok_len = '0;
          tok_start = '0;
          tok_slash = 1'b0;
        end else if (hs == HEX_BAD) begin
          emit_err = 1'b1;
        end
      end
      LN_INODE: begin
        if (c >= CH_0 && c <= CH_9) begin
          acc_inode = acc_inode * 32'd10 + 32'(c - CH_0);
          digit_seen = 1'b1;
          note_token(c, pos);
        end else if (!digit_seen) begin
          emit_err = 1'b1;
        end else begin
          ln_phase = LN_TAIL;
          emit_rec = tail_char(c, pos);
        end
      end
      LN_TAIL: emit_rec = tail_char(c, pos);
      default: ;
    endcase

    if (!emit_rec && !emit_err && eot && ln_phase != LN_SKIP) begin
      if (ln_phase == LN_TAIL || (ln_phase == LN_INODE && digit_seen)) emit_rec = 1'b1;
      else emit_err = 1'b1;
    end

    rec = '0;
    if (emit_rec) begin
      named = tok_slash && tok_len >= 2;
      rec.status = STATUS_RECORD;
      rec.start_addr = acc_start;
      rec.region_length = acc_end - acc_start;
      rec.protection = acc_perm;
      rec.device = (acc_major << 8) + acc_minor;
      rec.inode = acc_inode;
      if (named) begin
        rec.file_offset = acc_offset;
        rec.has_name = 1'b1;
        rec.name_pos = tok_start;
        rec.name_len = tok_len;
      end
      expected_records.push_back(rec);
      records_predicted++;
      clear_line_state();
      ln_phase = LN_START;
    end else if (emit_err) begin
      rec.status = STATUS_ERROR;
      expected_records.push_back(rec);
      records_predicted++;
      clear_line_state();
      ln_phase = LN_SKIP;
    end

    if (eot) begin
      clear_line_state();
      ln_phase = LN_START;
      text_pos = '0;
    end else begin
      text_pos = pos + 1;
    end
  endfunction

  // result checking
  function automatic void check_field(input string fname, input logic [63:0] want,
                                      input logic [63:0] got);
    if (want !== got) begin
      mismatches++;
      if (mismatches <= MAX_REPORTS)
        $display("result %s: expected %h, got %h", fname, want, got);
    end
  endfunction

  function automatic void check_result();
    mmlp_result_t want;
    if (expected_records.size() == 0) begin
      mismatches++;
      if (mismatches <= MAX_REPORTS)
        $display("unexpected result word, status %b", status);
      return;
    end
    want = expected_records.pop_front();
    check_field("status", 64'(want.status), 64'(status));
    check_field("start_addr", want.start_addr, start_addr);
    check_field("region_length", want.region_length, region_length);
    check_field("protection", 64'(want.protection), 64'(protection));
    check_field("device", 64'(want.device), 64'(device));
    check_field("inode", 64'(want.inode), 64'(inode));
    check_field("file_offset", want.file_offset, file_offset);
    check_field("has_name", 64'(want.has_name), 64'(has_name));
    check_field("name_pos", 64'(want.name_pos), 64'(name_pos));
    check_field("name_len", 64'(want.name_len), 64'(name_len));
  endfunction

  always @(posedge clk) begin
    if (!rst && result_valid && result_ready) check_result();
  end

  // receiver stall pattern with long hold-offs on request
  always @(negedge clk) begin
    if (hold_requests != holds_served) begin
      holds_served++;
      hold_left = HOLD_CYCLES;
    end
    if (mode_left == 0) begin
      ready_mode = $urandom_range(RDY_ALWAYS, RDY_SPARSE);
      mode_left = $urandom_range(8, 64);
    end else begin
      mode_left--;
    end
    if (hold_left != 0) begin
      hold_left--;
      result_ready <= 1'b0;
    end else begin
      case (ready_mode)
        RDY_ALWAYS: result_ready <= 1'b1;
        RDY_HALF:   result_ready <= ($urandom_range(0, 1) == 1);
        default:    result_ready <= ($urandom_range(0, 3) == 0);
      endcase
    end
  end

  always @(posedge clk) begin
    if ((text_valid && text_ready) || (result_valid && result_ready)) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
  end

  initial begin
    wait (idle_cycles >= IDLE_LIMIT);
    $display("tb_memory_map_line_parser: done, errors");
    $finish;
  end

  // text building
  function automatic void put_byte(input logic [7:0] b);
    text_q.push_back(b);
  endfunction

  function automatic void put_str(input string s);
    for (int i = 0; i < s.len(); i++) text_q.push_back(s[i]);
  endfunction

  function automatic void put_hex(input logic [79:0] v, input int nd);
    logic [3:0] d;
    for (int i = nd - 1; i >= 0; i--) begin
      d = v[4*i +: 4];
      if ($urandom_range(0, 1) == 1) text_q.push_back(HEX_UPPER[d]);
      else text_q.push_back(HEX_LOWER[d]);
    end
  endfunction

  function automatic void put_decimal(input int nd);
    repeat (nd) text_q.push_back(8'(CH_0 + $urandom_range(0, 9)));
  endfunction

  function automatic void put_blanks(input int n);
    repeat (n) begin
      case ($urandom_range(0, 7))
        0: put_byte(CH_TAB);
        1: put_byte(CH_VT);
        2: put_byte(CH_FF);
        3: put_byte(CH_CR);
        default: put_byte(CH_SPACE);
      endcase
    end
  endfunction

  function automatic void put_name(input int n);
    logic [7:0] b;
    repeat (n) begin
      b = NAME_CHARS[$urandom_range(0, NAME_CHARS.len() - 1)];
      if ($urandom_range(0, 7) == 0) begin
        b = 8'($urandom_range(0, 255));
        if (is_blank(b)) b = CH_SLASH;
      end
      put_byte(b);
    end
  endfunction

  function automatic logic [79:0] rand_wide();
    return 80'({$urandom, $urandom, $urandom});
  endfunction

  function automatic int pick_digits(input int typical, input int longest);
    if ($urandom_range(0, 7) == 0) return $urandom_range(1, longest);
    return $urandom_range(1, typical);
  endfunction

  function automatic void add_random_line();
    int first;
    int kind;
    first = text_q.size();
    put_hex(rand_wide(), pick_digits(4, 20));
    put_byte(CH_DASH);
    put_hex(rand_wide(), pick_digits(4, 20));
    put_byte(CH_SPACE);
    put_byte(($urandom_range(0, 1) == 1) ? CH_R : CH_DASH);
    put_byte(($urandom_range(0, 1) == 1) ? CH_W : CH_DASH);
    put_byte(($urandom_range(0, 1) == 1) ? CH_X : CH_DASH);
    case ($urandom_range(0, 2))
      0: put_byte(CH_P);
      1: put_byte(CH_S);
      default: put_byte(CH_DASH);
    endcase
    put_byte(CH_SPACE);
    put_hex(rand_wide(), pick_digits(3, 18));
    put_byte(CH_SPACE);
    put_hex(rand_wide(), pick_digits(2, 10));
    put_byte(CH_COLON);
    put_hex(rand_wide(), pick_digits(2, 10));
    put_byte(CH_SPACE);
    put_decimal(pick_digits(3, 12));
    kind = $urandom_range(0, 7);
    if (kind != 0 && kind != 4) put_blanks($urandom_range(1, 3));
    case (kind)
      1, 4: begin
        put_byte(CH_SLASH);
        put_name($urandom_range(0, 8));
      end
      2: put_str("[heap]");
      3: put_byte(CH_SLASH);
      5: begin
        put_byte(CH_SLASH);
        put_name($urandom_range(1, 8));
        put_blanks($urandom_range(1, 2));
      end
      6: put_name($urandom_range(1, 8));
      7: begin
        put_byte(CH_SLASH);
        put_name($urandom_range(1, 6));
        put_str(" (deleted)");
      end
      default: ;
    endcase
    if ($urandom_range(0, 11) == 0)
      text_q[$urandom_range(first, text_q.size() - 1)] = 8'($urandom_range(0, 255));
    put_byte(CH_NL);
  endfunction

  // sending
  task automatic send_byte(input logic [7:0] b, input logic eot);
    text_byte = b;
    end_of_text = eot;
    text_valid = 1'b1;
    @(posedge clk);
    while (!text_ready) @(posedge clk);
    parse_map_byte(b, eot);
    bytes_sent++;
    @(negedge clk);
    if (burst_left == 0) begin
      text_valid = 1'b0;
      repeat ($urandom_range(1, 6)) @(negedge clk);
      burst_left = $urandom_range(1, 40);
    end else begin
      burst_left--;
    end
  endtask

  task automatic send_text(input logic eot_last);
    int n;
    n = text_q.size();
    for (int i = 0; i < n; i++) send_byte(text_q[i], eot_last && (i == n - 1));
    text_q.delete();
  endtask

  task automatic wait_drained();
    text_valid = 1'b0;
    while (expected_records.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
    @(negedge clk);
  endtask

  // tests
  task automatic test_field_extremes();
    put_str("ffffffffffffffff-0 rwxs ffffffffffffffff ffffffff:ffffffff 4294967295 /x");
    put_byte(CH_NL);
    put_str("123456789abcdef0123-FEDCBA9876543210Ab --xp DeadBeefCafeF00d1 ");
    put_str("123456789:fff 99999999999 /lib/libc.so");
    send_text(1'b1);
    put_str("0-0 ---- 0 0:0 0");
    send_text(1'b1);
    wait_drained();
  endtask

  task automatic test_line_endings();
    put_str("0-1 r-x- 0 0:0 7");
    put_byte(CH_NL);
    put_byte(CH_NL);
    send_text(1'b1);
    put_str("1-2 -w-p 10 1:2 5");
    send_text(1'b1);
    put_str("1-2 r");
    send_text(1'b1);
    put_byte(CH_NL);
    put_str("1-2 ---p 0 0:0 1");
    put_byte(CH_NL);
    send_text(1'b1);
    put_str("a-b ---p 0 0:0 1 /x");
    put_byte(CH_NL);
    send_text(1'b1);
    put_str("1");
    send_text(1'b1);
    wait_drained();
  endtask

  task automatic test_syntax_errors();
    put_str("-1 ---p 0 0:0 1");
    send_text(1'b1);
    put_str("g-1 ---p 0 0:0 1");
    send_text(1'b1);
    put_byte(8'hFF);
    put_str("1-2");
    send_text(1'b1);
    put_str("1-2 rwxq 0 0:0 1");
    send_text(1'b1);
    put_str("1-2 rwxpx0 0:0 1");
    send_text(1'b1);
    put_str("1-2 ---p 0 0-0 1");
    send_text(1'b1);
    put_str("1-2 ---p 0 0:0 x");
    put_byte(CH_NL);
    send_text(1'b1);
    put_str("1-2  ---p 0 0:0 1");
    send_text(1'b1);
    wait_drained();
  endtask

  task automatic test_name_token();
    put_str("1-2 r--p 4 0:0 12/ab");
    put_byte(CH_NL);
    put_str("1-2 r--p 4 0:0 12");
    put_byte(CH_TAB);
    put_str("/ab");
    put_byte(CH_NL);
    put_str("1-2 r--p 4 0:0 1 /");
    put_byte(CH_NL);
    put_str("1-2 r--p 4 0:0 1 [heap]");
    put_byte(CH_NL);
    put_str("1-2 r--p 4 0:0 1 /lib ");
    put_byte(CH_NL);
    put_str("1-2 r--p 4 0:0 1 /a");
    put_byte(8'h00);
    put_str("b");
    put_byte(8'h80);
    put_byte(CH_CR);
    put_str("/c");
    put_byte(CH_VT);
    put_byte(CH_FF);
    put_str("/dd");
    put_byte(CH_NL);
    put_str("7-3 r--p abc 0:0 9 /tail/no/newline");
    send_text(1'b1);
    wait_drained();
  endtask

  task automatic test_backpressure();
    hold_requests++;
    repeat (4) begin
      put_str("1-2 ---p 0 0:0 3 /f");
      put_byte(CH_NL);
    end
    send_text(1'b1);
    wait_drained();
  endtask

  task automatic test_random_text();
    int bytes0;
    int recs0;
    int mark;
    begin
      bytes0 = bytes_sent;
      recs0 = records_predicted;
      while ((bytes_sent - bytes0) < RANDOM_BYTES ||
             (records_predicted - recs0) < RANDOM_RESULTS) begin
        repeat ($urandom_range(1, 4)) add_random_line();
        case ($urandom_range(0, 9))
          0: void'(text_q.pop_back());
          1: begin
            mark = text_q.size();
            add_random_line();
            repeat ($urandom_range(1, text_q.size() - mark - 1)) void'(text_q.pop_back());
          end
          2: repeat ($urandom_range(1, 8)) put_byte(8'($urandom_range(0, 255)));
          default: ;
        endcase
        send_text(1'b1);
        if ($urandom_range(0, 15) == 0) hold_requests++;
      end
      wait_drained();
    end
  endtask

  initial begin
    clear_line_state();
    repeat (8) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;
    test_field_extremes();
    test_line_endings();
    test_syntax_errors();
    test_name_token();
    test_backpressure();
    test_random_text();
    wait_drained();
    if (mismatches == 0 && expected_records.size() == 0) begin
      $display("tb_memory_map_line_parser: done, clean");
    end else begin
      $display("tb_memory_map_line_parser: done, errors");
    end
    $finish;
  end

endmodule
